FILE: hw/rtl/jfhs_pkg.sv
package jfhs_pkg;

    localparam int BYTE_COUNT_BITS = 32;
    localparam int CFG_BITS        = 32;
    localparam int CMP_BITS        = 64;

    localparam logic [CFG_BITS-1:0] MAX_FILE_BYTES_RESET = 32'd67108864;

    localparam logic [7:0] MARK_FILL  = 8'hFF;
    localparam logic [7:0] MARK_SOI   = 8'hD8;
    localparam logic [7:0] MARK_EOI   = 8'hD9;
    localparam logic [7:0] MARK_SOS   = 8'hDA;
    localparam logic [7:0] MARK_TEM   = 8'h01;
    localparam logic [7:0] MARK_RST0  = 8'hD0;
    localparam logic [7:0] MARK_RST7  = 8'hD7;
    localparam logic [7:0] MARK_SOF0  = 8'hC0;
    localparam logic [7:0] MARK_SOF1  = 8'hC1;
    localparam logic [7:0] MARK_SOF2  = 8'hC2;

    localparam logic [15:0] SEG_LEN_MIN      = 16'd2;
    localparam logic [15:0] SOF_LEN_MIN      = 16'd11;
    localparam logic [15:0] SOF_LEN_FULL     = 16'd17;
    localparam logic [7:0]  COMPONENTS_RGB   = 8'd3;
    localparam logic [CMP_BITS-1:0] FILE_MIN = 64'd4;

    // Byte positions inside the frame header body
    localparam logic [3:0] OFS_HEIGHT_HI = 4'd1;
    localparam logic [3:0] OFS_HEIGHT_LO = 4'd2;
    localparam logic [3:0] OFS_WIDTH_HI  = 4'd3;
    localparam logic [3:0] OFS_WIDTH_LO  = 4'd4;
    localparam logic [3:0] OFS_COMPS     = 4'd5;
    localparam logic [3:0] OFS_SAMPLING  = 4'd7;
    localparam logic [3:0] OFS_LAST      = 4'd8;

    typedef enum logic [9:0] {
        PH_SOI0       = 10'b00_0000_0001,
        PH_SOI1       = 10'b00_0000_0010,
        PH_SCAN       = 10'b00_0000_0100,
        PH_FILL       = 10'b00_0000_1000,
        PH_LEN_HI     = 10'b00_0001_0000,
        PH_LEN_LO     = 10'b00_0010_0000,
        PH_SKIP       = 10'b00_0100_0000,
        PH_SOF_LEN_HI = 10'b00_1000_0000,
        PH_SOF_LEN_LO = 10'b01_0000_0000,
        PH_SOF_BODY   = 10'b10_0000_0000
    } phase_t;

    typedef enum logic [2:0] {
        V_UNDECIDED = 3'b001,
        V_FAIL      = 3'b010,
        V_PASS      = 3'b100
    } verdict_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [15:0] image_height;
        logic [15:0] image_width;
        logic [7:0]  subsampling;
    } out_item_t;

endpackage

FILE: hw/rtl/jpeg_frame_header_scanner.sv
// JPEG frame header scanner.
// Feed a file one byte per item on the s_ channel, with last_byte set on the
// final byte. The block checks the SOI marker, walks the marker segments and
// captures height, width and the first sampling byte from the first SOF0/1/2
// header of length 11 or more. Exactly one result item leaves on the m_ channel
// per file, for the item that carries last_byte; found is 0 and all other
// fields are zero when the file is rejected. Other bytes produce no result.
// Throughput: one byte per cycle. An accepted item is held in the input
// register and scanned from there; the result of a final byte is registered
// in the output register and then valid on m_. The limit is the one-step marker
// state update done per byte. max_file_bytes is written on the cfg_ channel
// (always ready); the user must write it only while the block is idle, and
// the block does not enforce this. Reset loads 64 MiB, clears all scan state
// and empties both registers. When the receiver stalls, the result waits in
// the output register; non-final bytes keep flowing, and the final byte of
// the next file waits in the input register until the pending result is taken.
module jpeg_frame_header_scanner (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  jfhs_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output jfhs_pkg::out_item_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [jfhs_pkg::CFG_BITS-1:0] cfg_data
);
    import jfhs_pkg::*;

    in_item_t            in_reg;
    logic                in_valid_reg, in_valid_next;
    out_item_t           out_reg;
    logic                m_valid_reg, m_valid_next;
    logic [CFG_BITS-1:0] max_bytes_reg;
    out_item_t           result;
    logic                out_free;
    logic                step;
    logic                s_take;

    assign out_free  = !m_valid_reg || m_ready;
    // a non-final byte never needs the output slot
    assign step      = in_valid_reg && (out_free || !in_reg.last_byte);
    assign s_ready   = !in_valid_reg || step;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    jfhs_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .item           (in_reg),
        .max_file_bytes (max_bytes_reg),
        .result         (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take)    in_valid_next = 1'b1;
        else if (step) in_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (step && in_reg.last_byte) m_valid_next = 1'b1;
        else if (m_ready)             m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            max_bytes_reg <= MAX_FILE_BYTES_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) max_bytes_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) in_reg <= s_data;
        if (step && in_reg.last_byte) out_reg <= result;
    end

endmodule

FILE: hw/rtl/jfhs_parser.sv
module jfhs_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  jfhs_pkg::in_item_t           item,
    input  logic [jfhs_pkg::CFG_BITS-1:0] max_file_bytes,
    output jfhs_pkg::out_item_t          result
);
    import jfhs_pkg::*;

    phase_t                     phase_reg, phase_next;
    verdict_t                   verdict_reg, verdict_next;
    logic [BYTE_COUNT_BITS-1:0] count_reg, count_next;
    logic [15:0]                remain_reg, remain_next;
    logic [7:0]                 len_hi_reg, len_hi_next;
    logic [3:0]                 offset_reg, offset_next;
    logic [15:0]                height_reg, height_next;
    logic [15:0]                width_reg, width_next;
    logic                       comps_ok_reg, comps_ok_next;
    logic [7:0]                 sampling_reg, sampling_next;
    logic                       sof_long_reg, sof_long_next;

    logic [7:0]  b;
    logic [15:0] seg_len;
    logic [15:0] remain_dec;
    logic        pass;

    assign b          = item.data_byte;
    assign seg_len    = {len_hi_reg, b};
    assign remain_dec = remain_reg - 16'd1;

    always_comb begin
        phase_next    = phase_reg;
        verdict_next  = verdict_reg;
        remain_next   = remain_reg;
        len_hi_next   = len_hi_reg;
        offset_next   = offset_reg;
        height_next   = height_reg;
        width_next    = width_reg;
        comps_ok_next = comps_ok_reg;
        sampling_next = sampling_reg;
        sof_long_next = sof_long_reg;

        // saturate the file length at all ones
        count_next = (&count_reg) ? count_reg : count_reg + 1'b1;

        if (verdict_reg == V_UNDECIDED) begin
            unique case (phase_reg)
                PH_SOI0: begin
                    if (b == MARK_FILL) phase_next = PH_SOI1;
                    else                verdict_next = V_FAIL;
                end
                PH_SOI1: begin
                    if (b == MARK_SOI) phase_next = PH_SCAN;
                    else               verdict_next = V_FAIL;
                end
                PH_SCAN: begin
                    if (b == MARK_FILL) phase_next = PH_FILL;
                end
                PH_FILL: begin
                    priority if (b == MARK_FILL) begin
                        phase_next = PH_FILL;
                    end else if (b == MARK_EOI || b == MARK_SOS) begin
                        verdict_next = V_FAIL;
                    end else if (b == MARK_TEM || (b >= MARK_RST0 && b <= MARK_RST7)) begin
                        phase_next = PH_SCAN;
                    end else if (b == MARK_SOF0 || b == MARK_SOF1 || b == MARK_SOF2) begin
                        phase_next = PH_SOF_LEN_HI;
                    end else begin
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    len_hi_next = b;
                    phase_next  = PH_LEN_LO;
                end
                PH_SOF_LEN_HI: begin
                    len_hi_next = b;
                    phase_next  = PH_SOF_LEN_LO;
                end
                PH_LEN_LO, PH_SOF_LEN_LO: begin
                    if (seg_len < SEG_LEN_MIN) begin
                        verdict_next = V_FAIL;
                    end else begin
                        remain_next = seg_len - SEG_LEN_MIN;
                        if (phase_reg == PH_SOF_LEN_LO && seg_len >= SOF_LEN_MIN) begin
                            sof_long_next = (seg_len >= SOF_LEN_FULL);
                            offset_next   = '0;
                            phase_next    = PH_SOF_BODY;
                        end else if (seg_len == SEG_LEN_MIN) begin
                            phase_next = PH_SCAN;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    remain_next = remain_dec;
                    if (remain_dec == '0) phase_next = PH_SCAN;
                end
                PH_SOF_BODY: begin
                    unique case (offset_reg)
                        OFS_HEIGHT_HI: height_next   = {b, 8'h00};
                        OFS_HEIGHT_LO: height_next   = {height_reg[15:8], b};
                        OFS_WIDTH_HI:  width_next    = {b, 8'h00};
                        OFS_WIDTH_LO:  width_next    = {width_reg[15:8], b};
                        OFS_COMPS:     comps_ok_next = (b == COMPONENTS_RGB);
                        OFS_SAMPLING:  sampling_next = b;
                        default: ;
                    endcase
                    if (offset_reg < OFS_LAST) offset_next = offset_reg + 4'd1;
                    remain_next = remain_dec;
                    // decide on the last body byte, with this byte already taken
                    if (remain_dec == '0) begin
                        if (comps_ok_next && sof_long_reg &&
                            height_next != '0 && width_next != '0)
                            verdict_next = V_PASS;
                        else
                            verdict_next = V_FAIL;
                    end
                end
                default: verdict_next = V_FAIL;
            endcase
        end
    end

    assign pass = (verdict_next == V_PASS) &&
                  (CMP_BITS'(count_next) >= FILE_MIN) &&
                  (CMP_BITS'(count_next) <= CMP_BITS'(max_file_bytes));

    always_comb begin
        result.found        = pass;
        result.image_height = pass ? height_next   : '0;
        result.image_width  = pass ? width_next    : '0;
        result.subsampling  = pass ? sampling_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && item.last_byte)) begin
            // end of file: start over for the next one
            phase_reg    <= PH_SOI0;
            verdict_reg  <= V_UNDECIDED;
            count_reg    <= '0;
            remain_reg   <= '0;
            len_hi_reg   <= '0;
            offset_reg   <= '0;
            height_reg   <= '0;
            width_reg    <= '0;
            comps_ok_reg <= 1'b0;
            sampling_reg <= '0;
            sof_long_reg <= 1'b0;
        end else if (step) begin
            phase_reg    <= phase_next;
            verdict_reg  <= verdict_next;
            count_reg    <= count_next;
            remain_reg   <= remain_next;
            len_hi_reg   <= len_hi_next;
            offset_reg   <= offset_next;
            height_reg   <= height_next;
            width_reg    <= width_next;
            comps_ok_reg <= comps_ok_next;
            sampling_reg <= sampling_next;
            sof_long_reg <= sof_long_next;
        end
    end

endmodule

FILE: verif/tb_jpeg_frame_header_scanner.sv
`timescale 1ns / 100ps

module tb_jpeg_frame_header_scanner;
    import jfhs_pkg::*;

    localparam int STALL_LIMIT   = 400;
    localparam int SETTLE_CYCLES = 4;

    // Ordinary length-prefixed markers with no special meaning to the scanner
    localparam logic [7:0] MARK_APP0 = 8'hE0;
    localparam logic [7:0] MARK_COM  = 8'hFE;

    // Tracks the scan of the current file and queues the verdict of each file.
    class header_verdict_model;
        phase_t          phase;
        verdict_t        verdict;
        logic [31:0]     nbytes;
        logic [15:0]     seg_left;
        logic [7:0]      len_hi;
        logic [4:0]      body_ofs;
        logic [15:0]     height;
        logic [15:0]     width;
        logic [7:0]      comps;
        logic [7:0]      sampling;
        logic [15:0]     sof_len;
        logic [31:0]     max_bytes;
        out_item_t       pending_verdicts[$];
        int              errors;

        function new();
            max_bytes = MAX_FILE_BYTES_RESET;
            errors    = 0;
            restart();
        endfunction

        function void restart();
            phase    = PH_SOI0;
            verdict  = V_UNDECIDED;
            nbytes   = '0;
            seg_left = '0;
            len_hi   = '0;
            body_ofs = '0;
            height   = '0;
            width    = '0;
            comps    = '0;
            sampling = '0;
            sof_len  = '0;
        endfunction

        function void set_limit(logic [31:0] v);
            max_bytes = v;
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        function void scan_byte(logic [7:0] b);
            logic [15:0] len;
            case (phase)
                PH_SOI0: begin
                    if (b == MARK_FILL) phase = PH_SOI1;
                    else verdict = V_FAIL;
                end
                PH_SOI1: begin
                    if (b == MARK_SOI) phase = PH_SCAN;
                    else verdict = V_FAIL;
                end
                PH_SCAN: begin
                    if (b == MARK_FILL) phase = PH_FILL;
                end
                PH_FILL: begin
                    if (b == MARK_FILL) begin
                        // stay in the fill run
                    end else if (b == MARK_EOI || b == MARK_SOS) begin
                        verdict = V_FAIL;
                    end else if (b == MARK_TEM || (b >= MARK_RST0 && b <= MARK_RST7)) begin
                        phase = PH_SCAN;
                    end else if (b == MARK_SOF0 || b == MARK_SOF1 || b == MARK_SOF2) begin
                        phase = PH_SOF_LEN_HI;
                    end else begin
                        phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI, PH_SOF_LEN_HI: begin
                    len_hi = b;
                    if (phase == PH_LEN_HI) phase = PH_LEN_LO;
                    else phase = PH_SOF_LEN_LO;
                end
                PH_LEN_LO, PH_SOF_LEN_LO: begin
                    len = {len_hi, b};
                    if (len < SEG_LEN_MIN) begin
                        verdict = V_FAIL;
                    end else begin
                        seg_left = len - SEG_LEN_MIN;
                        if (phase == PH_SOF_LEN_LO && len >= SOF_LEN_MIN) begin
                            sof_len  = len;
                            body_ofs = '0;
                            phase    = PH_SOF_BODY;
                        end else if (seg_left == '0) begin
                            phase = PH_SCAN;
                        end else begin
                            phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    seg_left = seg_left - 16'd1;
                    if (seg_left == '0) phase = PH_SCAN;
                end
                PH_SOF_BODY: begin
                    case (body_ofs)
                        OFS_HEIGHT_HI: height = {b, 8'h00};
                        OFS_HEIGHT_LO: height = height | {8'h00, b};
                        OFS_WIDTH_HI:  width = {b, 8'h00};
                        OFS_WIDTH_LO:  width = width | {8'h00, b};
                        OFS_COMPS:     comps = b;
                        OFS_SAMPLING:  sampling = b;
                        default: ;
                    endcase
                    if (body_ofs < OFS_LAST) body_ofs = body_ofs + 5'd1;
                    seg_left = seg_left - 16'd1;
                    if (seg_left == '0) begin
                        if (comps == COMPONENTS_RGB && sof_len >= SOF_LEN_FULL &&
                            height != '0 && width != '0)
                            verdict = V_PASS;
                        else
                            verdict = V_FAIL;
                    end
                end
                default: verdict = V_FAIL;
            endcase
        endfunction

        function void note_input(in_item_t item);
            out_item_t v;
            if (nbytes != '1) nbytes = nbytes + 32'd1;
            if (verdict == V_UNDECIDED) scan_byte(item.data_byte);
            if (item.last_byte) begin
                v = '0;
                if (verdict == V_PASS && nbytes >= FILE_MIN && nbytes <= max_bytes) begin
                    v.found        = 1'b1;
                    v.image_height = height;
                    v.image_width  = width;
                    v.subsampling  = sampling;
                end
                pending_verdicts.push_back(v);
                restart();
            end
        endfunction

        function void check_verdict(out_item_t got);
            out_item_t want;
            if (pending_verdicts.size() == 0) begin
                $error("result with no file pending: found=%0d height=%0d width=%0d",
                       got.found, got.image_height, got.image_width);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                errors++;
            end
            if (got.image_height !== want.image_height) begin
                $error("image_height: expected %0d, got %0d",
                       want.image_height, got.image_height);
                errors++;
            end
            if (got.image_width !== want.image_width) begin
                $error("image_width: expected %0d, got %0d",
                       want.image_width, got.image_width);
                errors++;
            end
            if (got.subsampling !== want.subsampling) begin
                $error("subsampling: expected 0x%02h, got 0x%02h",
                       want.subsampling, got.subsampling);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_item_t           m_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_BITS-1:0] cfg_data;

    header_verdict_model sb;
    logic [7:0]          file_q[$];
    int                  bytes_sent;
    int                  idle_cycles;
    bit                  fast_send;
    bit                  fast_recv;

    jpeg_frame_header_scanner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ---- file construction ----

    function automatic logic [7:0] plain_marker();
        logic [7:0] m;
        do m = 8'($urandom);
        while (m == MARK_FILL || m == MARK_EOI || m == MARK_SOS || m == MARK_TEM ||
               (m >= MARK_RST0 && m <= MARK_RST7) ||
               m == MARK_SOF0 || m == MARK_SOF1 || m == MARK_SOF2);
        return m;
    endfunction

    function automatic logic [7:0] sof_marker();
        case ($urandom_range(0, 2))
            0: return MARK_SOF0;
            1: return MARK_SOF1;
            default: return MARK_SOF2;
        endcase
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic void add_segment(logic [7:0] marker, int len);
        file_q = {file_q, MARK_FILL, marker, 8'(len >> 8), 8'(len)};
        repeat (len - 2) file_q.push_back(8'($urandom));
    endfunction

    function automatic void add_sof(logic [7:0] marker, logic [15:0] len, logic [15:0] h,
                                    logic [15:0] w, logic [7:0] nc, logic [7:0] samp);
        int k;
        file_q = {file_q, MARK_FILL, marker, len[15:8], len[7:0]};
        for (k = 0; k < int'(len) - 2; k++) begin
            case (k)
                OFS_HEIGHT_HI: file_q.push_back(h[15:8]);
                OFS_HEIGHT_LO: file_q.push_back(h[7:0]);
                OFS_WIDTH_HI:  file_q.push_back(w[15:8]);
                OFS_WIDTH_LO:  file_q.push_back(w[7:0]);
                OFS_COMPS:     file_q.push_back(nc);
                OFS_SAMPLING:  file_q.push_back(samp);
                default:       file_q.push_back(8'($urandom));
            endcase
        end
    endfunction

    // Smallest passing file (21 bytes), padded with trailing bytes up to total.
    function automatic void build_min_frame(int total);
        file_q = {MARK_FILL, MARK_SOI};
        add_sof(MARK_SOF0, SOF_LEN_FULL, 16'd16, 16'd32, COMPONENTS_RGB, 8'h22);
        while (file_q.size() < total) file_q.push_back(8'($urandom));
    endfunction

    function automatic void build_random_file();
        int          kind;
        int          cut;
        logic [15:0] len;
        logic [7:0]  nc;
        kind = $urandom_range(0, 9);
        file_q = {MARK_FILL, MARK_SOI};
        if (kind == 0) begin
            // noise, sometimes behind a good SOI
            if ($urandom_range(0, 1) == 0) file_q.delete();
            repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 4))
                0: repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(0, 254)));
                1: begin
                    repeat ($urandom_range(1, 4)) file_q.push_back(MARK_FILL);
                    add_segment(plain_marker(), $urandom_range(2, 8));
                end
                2: begin
                    if ($urandom_range(0, 8) == 0)
                        file_q = {file_q, MARK_FILL, MARK_TEM};
                    else
                        file_q = {file_q, MARK_FILL, MARK_RST0 + 8'($urandom_range(0, 7))};
                end
                3: begin
                    if ($urandom_range(0, 9) == 0)
                        add_segment(plain_marker(), $urandom_range(0, 40));
                    else
                        add_segment(plain_marker(), $urandom_range(2, 8));
                end
                default: add_sof(sof_marker(), 16'($urandom_range(2, 10)), pick_dim(),
                                 pick_dim(), COMPONENTS_RGB, 8'($urandom));
            endcase
        end
        if ($urandom_range(0, 3) == 0) len = 16'($urandom_range(11, 16));
        else len = 16'($urandom_range(17, 22));
        if ($urandom_range(0, 3) == 0) nc = 8'($urandom_range(0, 5));
        else nc = COMPONENTS_RGB;
        add_sof(sof_marker(), len, pick_dim(), pick_dim(), nc, 8'($urandom));
        repeat ($urandom_range(0, 5)) file_q.push_back(8'($urandom));
        if (kind == 1) begin
            cut = $urandom_range(1, file_q.size());
            while (file_q.size() > cut) void'(file_q.pop_back());
        end else if (kind == 2) begin
            file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
        end
    endfunction

    // ---- drivers ----

    task automatic send_byte(in_item_t item);
        int gap;
        gap = fast_send ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(item);
    endtask

    task automatic send_file();
        int       i;
        int       n;
        in_item_t item;
        n = file_q.size();
        for (i = 0; i < n; i++) begin
            item.data_byte = file_q[i];
            item.last_byte = (i == n - 1);
            send_byte(item);
        end
        bytes_sent += n;
        file_q.delete();
    endtask

    // Hold the sender until every verdict is back and the scanner is quiet.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(logic [31:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_limit(v);
    endtask

    task automatic run_random(int byte_budget, int file_min);
        int start;
        int files;
        start = bytes_sent;
        files = 0;
        while (bytes_sent - start < byte_budget || files < file_min) begin
            build_random_file();
            fast_send = ($urandom_range(0, 3) == 0);
            send_file();
            files++;
            if ($urandom_range(0, 9) == 0) drain();
        end
    endtask

    task automatic run_directed();
        file_q = {MARK_FILL, MARK_SOI, MARK_FILL};
        send_file();
        build_min_frame(21);
        send_file();
        // all-ones frame, with an EOI after the verdict is decided
        file_q = {MARK_FILL, MARK_SOI};
        add_sof(MARK_SOF2, SOF_LEN_FULL, 16'hFFFF, 16'hFFFF, COMPONENTS_RGB, 8'hFF);
        file_q = {file_q, MARK_FILL, MARK_EOI, 8'h00};
        send_file();
        build_min_frame(21);
        file_q[0] = 8'h00;
        send_file();
        build_min_frame(21);
        file_q[1] = MARK_EOI;
        send_file();
        // junk, fill run, standalone markers, empty and plain segments, SOI as a segment
        file_q = {MARK_FILL, MARK_SOI, 8'h00, 8'h7F, MARK_FILL, MARK_FILL, MARK_FILL, MARK_TEM,
                  MARK_FILL, MARK_RST0, MARK_FILL, MARK_RST7};
        add_segment(MARK_APP0, 2);
        add_segment(MARK_COM, 6);
        add_segment(MARK_SOI, 3);
        add_sof(MARK_SOF1, 16'd18, 16'd1, 16'd1, COMPONENTS_RGB, 8'h11);
        send_file();
        // short SOF gets skipped, the next one decides
        file_q = {MARK_FILL, MARK_SOI};
        add_sof(MARK_SOF0, 16'd8, 16'd7, 16'd7, COMPONENTS_RGB, 8'h11);
        add_sof(MARK_SOF2, SOF_LEN_FULL, 16'd480, 16'd640, COMPONENTS_RGB, 8'h21);
        send_file();
        file_q = {MARK_FILL, MARK_SOI, MARK_FILL, MARK_EOI};
        add_sof(MARK_SOF0, SOF_LEN_FULL, 16'd8, 16'd8, COMPONENTS_RGB, 8'h11);
        send_file();
        file_q = {MARK_FILL, MARK_SOI, MARK_FILL, MARK_SOS};
        add_sof(MARK_SOF0, SOF_LEN_FULL, 16'd8, 16'd8, COMPONENTS_RGB, 8'h11);
        send_file();
        file_q = {MARK_FILL, MARK_SOI};
        add_segment(MARK_APP0, 1);
        add_sof(MARK_SOF0, SOF_LEN_FULL, 16'd8, 16'd8, COMPONENTS_RGB, 8'h11);
        send_file();
        // stream ends inside a segment, after a marker, inside a length
        file_q = {MARK_FILL, MARK_SOI};
        add_segment(MARK_APP0, 16);
        while (file_q.size() > 10) void'(file_q.pop_back());
        send_file();
        file_q = {MARK_FILL, MARK_SOI, MARK_FILL, MARK_SOF0};
        send_file();
        file_q = {MARK_FILL, MARK_SOI, MARK_FILL, MARK_SOF0, 8'h00};
        send_file();
        file_q = {MARK_FILL, MARK_SOI};
        add_sof(MARK_SOF0, SOF_LEN_FULL, 16'd5, 16'd5, 8'd1, 8'h11);
        send_file();
        file_q = {MARK_FILL, MARK_SOI};
        add_sof(MARK_SOF1, SOF_LEN_FULL - 16'd1, 16'd5, 16'd5, COMPONENTS_RGB, 8'h11);
        send_file();
        file_q = {MARK_FILL, MARK_SOI};
        add_sof(MARK_SOF2, SOF_LEN_MIN, 16'd5, 16'd5, COMPONENTS_RGB, 8'h11);
        send_file();
        file_q = {MARK_FILL, MARK_SOI};
        add_sof(MARK_SOF0, SOF_LEN_FULL, 16'd0, 16'd5, COMPONENTS_RGB, 8'h11);
        send_file();
        file_q = {MARK_FILL, MARK_SOI};
        add_sof(MARK_SOF0, SOF_LEN_FULL, 16'd5, 16'd0, COMPONENTS_RGB, 8'h11);
        send_file();
    endtask

    // ---- result side ----

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = fast_recv ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if ($urandom_range(0, 4) == 0) fast_recv = !fast_recv;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_verdict(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        fast_send   = 1'b0;
        fast_recv   = 1'b0;
        bytes_sent  = 0;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_random(180, 5);

        write_limit(32'hFFFF_FFFF);
        run_random(180, 5);

        write_limit(32'd0);
        build_min_frame(21);
        send_file();
        run_random(60, 3);

        // passing files right at and just past the limit
        write_limit(32'd24);
        build_min_frame(24);
        send_file();
        build_min_frame(25);
        send_file();
        run_random(180, 5);

        write_limit(MAX_FILE_BYTES_RESET);
        run_random(180, 5);

        drain();
        repeat (6) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/jfhs_pkg.sv
hw/rtl/jfhs_parser.sv
hw/rtl/jpeg_frame_header_scanner.sv
verif/tb_jpeg_frame_header_scanner.sv
